// ===== design/brc_pkg.sv =====
// Shared types, constants and helpers for the barometer reading compensation core.
package brc_pkg;

  localparam logic [31:0] K_B6_OFS    = 32'd4000;
  localparam logic [31:0] K_P_C1      = 32'd3038;
  localparam logic [31:0] K_P_C2      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] K_P_C3      = 32'd3791;
  localparam logic [31:0] K_B7_SCALE  = 32'd50000;
  localparam logic [31:0] K_B4_OFS    = 32'd32768;
  localparam logic [31:0] K_SIGN      = 32'h8000_0000;
  localparam logic [31:0] K_P_MAX     = 32'd262143;
  localparam logic [31:0] K_T_MAX     = 32'sd32767;
  localparam logic [31:0] K_T_MIN     = 32'hFFFF_8000;

  typedef enum logic [2:0] {
    REG_OSS        = 3'd0,
    REG_AC1        = 3'd1,
    REG_AC2        = 3'd2,
    REG_AC3        = 3'd3,
    REG_AC4        = 3'd4,
    REG_B1         = 3'd5,
    REG_B2         = 3'd6,
    REG_TEMP_COEFS = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_T_MUL,
    OP_T_X1,
    OP_T_CHK,
    OP_T_FIN,
    OP_T_FLT,
    OP_P_SQ,
    OP_P_X1,
    OP_P_X2,
    OP_P_B3,
    OP_P_X4,
    OP_P_B4M,
    OP_P_B7M,
    OP_P_DIVS,
    OP_P_P,
    OP_P_X1P,
    OP_P_X2P,
    OP_P_FIN,
    OP_P_FLT
  } op_t;

  typedef struct packed {
    logic latch;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic b4_zero;
    logic div_done;
  } status_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    asr32 = $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== design/brc_div.sv =====
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module brc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // keep the difference when it does not borrow
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
      end else begin
        rem_nxt = shifted[31:0];
      end
      quo_nxt = {quo_r[30:0], ~diff[32]};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

// ===== design/brc_dp.sv =====
// Datapath: configuration registers, shared multiplier, divider and result registers.
module brc_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_idx,
  input  logic [63:0]     cfg_wdata,
  input  logic [23:0]     in_raw,
  input  brc_pkg::cmd_t   cmd,
  output brc_pkg::status_t status,
  output logic            res_kind,
  output logic [15:0]     res_temp,
  output logic [17:0]     res_press,
  output logic            res_fault
);

  logic [1:0]  oss_r;
  logic [15:0] ac1_r, ac2_r, ac3_r, ac4_r, b1_r, b2_r;
  logic [63:0] tc_r;
  logic [31:0] b5_r, b5_nxt;
  logic [23:0] raw_r;
  logic [31:0] prod_r, acc_r, acc_nxt, sq_r, b3_r, b4_r, b7_r, p_r;
  logic        neg_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [31:0] b6, up, scale, den, mc, md, x3, b3v, tmp, q, t32, pn, pv;
  logic        div_start;
  logic [31:0] div_dvd, div_dvs, quo;
  logic        div_done;

  logic        kind_r;
  logic [15:0] temp_r;
  logic [17:0] press_r;
  logic        fault_r;

  brc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quo),
    .done     (div_done)
  );

  assign b6  = b5_r - brc_pkg::K_B6_OFS;
  assign mc  = brc_pkg::sext16(tc_r[31:16]);
  assign md  = brc_pkg::sext16(tc_r[15:0]);
  assign den = acc_r + md;
  assign scale = brc_pkg::K_B7_SCALE >> oss_r;

  always_comb begin
    case (oss_r)
      2'd0:    up = {8'd0, raw_r} >> 8;
      2'd1:    up = {8'd0, raw_r} >> 7;
      2'd2:    up = {8'd0, raw_r} >> 6;
      default: up = {8'd0, raw_r} >> 5;
    endcase
  end

  assign status.den_zero = (den == '0);
  assign status.b4_zero  = (b4_r == '0);
  assign status.div_done = div_done;

  assign mul_full = mul_a * mul_b;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    acc_nxt   = acc_r;
    b5_nxt    = b5_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    x3        = '0;
    b3v       = '0;
    tmp       = '0;
    q         = '0;
    t32       = '0;
    pn        = '0;
    pv        = '0;
    case (cmd.op)
      brc_pkg::OP_T_MUL: begin
        mul_a = {16'd0, raw_r[15:0]} - {16'd0, tc_r[47:32]};
        mul_b = {16'd0, tc_r[63:48]};
      end
      brc_pkg::OP_T_X1: acc_nxt = brc_pkg::asr32(prod_r, 5'd15);
      brc_pkg::OP_T_CHK: begin
        div_start = (den != '0);
        tmp       = mc << 11;
        div_dvd   = mc[31] ? (32'd0 - tmp) : tmp;
        div_dvs   = den[31] ? (32'd0 - den) : den;
      end
      brc_pkg::OP_T_FIN: begin
        q      = neg_r ? (32'd0 - quo) : quo;
        b5_nxt = acc_r + q;
        t32    = brc_pkg::asr32(b5_nxt + 32'd8, 5'd4);
      end
      brc_pkg::OP_P_SQ: begin
        mul_a = b6;
        mul_b = b6;
      end
      brc_pkg::OP_P_X1: begin
        mul_a = brc_pkg::sext16(b2_r);
        mul_b = brc_pkg::asr32(prod_r, 5'd12);
      end
      brc_pkg::OP_P_X2: begin
        acc_nxt = brc_pkg::asr32(prod_r, 5'd11);
        mul_a   = brc_pkg::sext16(ac2_r);
        mul_b   = b6;
      end
      brc_pkg::OP_P_B3: begin
        x3    = acc_r + brc_pkg::asr32(prod_r, 5'd11);
        tmp   = (brc_pkg::sext16(ac1_r) << 2) + x3;
        b3v   = brc_pkg::asr32((tmp << oss_r) + 32'd2, 5'd2);
        mul_a = brc_pkg::sext16(ac3_r);
        mul_b = b6;
      end
      brc_pkg::OP_P_X4: begin
        acc_nxt = brc_pkg::asr32(prod_r, 5'd13);
        mul_a   = brc_pkg::sext16(b1_r);
        mul_b   = sq_r;
      end
      brc_pkg::OP_P_B4M: begin
        x3    = brc_pkg::asr32(acc_r + brc_pkg::asr32(prod_r, 5'd16) + 32'd2, 5'd2);
        mul_a = {16'd0, ac4_r};
        mul_b = x3 + brc_pkg::K_B4_OFS;
      end
      brc_pkg::OP_P_B7M: begin
        mul_a = up - b3_r;
        mul_b = scale;
      end
      brc_pkg::OP_P_DIVS: begin
        div_start = (b4_r != '0);
        div_dvd   = (prod_r < brc_pkg::K_SIGN) ? (prod_r << 1) : prod_r;
        div_dvs   = b4_r;
      end
      brc_pkg::OP_P_P: begin
        pv    = (b7_r < brc_pkg::K_SIGN) ? quo : (quo << 1);
        mul_a = brc_pkg::asr32(pv, 5'd8);
        mul_b = brc_pkg::asr32(pv, 5'd8);
      end
      brc_pkg::OP_P_X1P: begin
        mul_a = prod_r;
        mul_b = brc_pkg::K_P_C1;
      end
      brc_pkg::OP_P_X2P: begin
        acc_nxt = brc_pkg::asr32(prod_r, 5'd16);
        mul_a   = brc_pkg::K_P_C2;
        mul_b   = p_r;
      end
      brc_pkg::OP_P_FIN: begin
        tmp = acc_r + brc_pkg::asr32(prod_r, 5'd16) + brc_pkg::K_P_C3;
        pn  = p_r + brc_pkg::asr32(tmp, 5'd4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r <= '0;
      ac1_r <= '0;
      ac2_r <= '0;
      ac3_r <= '0;
      ac4_r <= '0;
      b1_r  <= '0;
      b2_r  <= '0;
      tc_r  <= '0;
      b5_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          brc_pkg::REG_OSS:        oss_r <= cfg_wdata[1:0];
          brc_pkg::REG_AC1:        ac1_r <= cfg_wdata[15:0];
          brc_pkg::REG_AC2:        ac2_r <= cfg_wdata[15:0];
          brc_pkg::REG_AC3:        ac3_r <= cfg_wdata[15:0];
          brc_pkg::REG_AC4:        ac4_r <= cfg_wdata[15:0];
          brc_pkg::REG_B1:         b1_r  <= cfg_wdata[15:0];
          brc_pkg::REG_B2:         b2_r  <= cfg_wdata[15:0];
          brc_pkg::REG_TEMP_COEFS: tc_r  <= cfg_wdata;
          default: ;
        endcase
      end
      b5_r <= b5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) raw_r <= in_raw;
    // hold the last product while no step runs, so a stalled final step keeps it
    if (cmd.op != brc_pkg::OP_NONE) prod_r <= mul_full[31:0];
    acc_r  <= acc_nxt;
    if (cmd.op == brc_pkg::OP_P_X1)   sq_r  <= brc_pkg::asr32(prod_r, 5'd12);
    if (cmd.op == brc_pkg::OP_P_B3)   b3_r  <= b3v;
    if (cmd.op == brc_pkg::OP_P_B7M)  b4_r  <= prod_r >> 15;
    if (cmd.op == brc_pkg::OP_P_DIVS) b7_r  <= prod_r;
    if (cmd.op == brc_pkg::OP_P_P)    p_r   <= pv;
    if (cmd.op == brc_pkg::OP_T_CHK)  neg_r <= mc[31] ^ den[31];
    case (cmd.op)
      brc_pkg::OP_T_FIN: begin
        kind_r  <= 1'b0;
        press_r <= '0;
        fault_r <= 1'b0;
        if ($signed(t32) > $signed(brc_pkg::K_T_MAX)) begin
          temp_r <= 16'h7FFF;
        end else if ($signed(t32) < $signed(brc_pkg::K_T_MIN)) begin
          temp_r <= 16'h8000;
        end else begin
          temp_r <= t32[15:0];
        end
      end
      brc_pkg::OP_T_FLT: begin
        kind_r  <= 1'b0;
        temp_r  <= '0;
        press_r <= '0;
        fault_r <= 1'b1;
      end
      brc_pkg::OP_P_FIN: begin
        kind_r  <= 1'b1;
        temp_r  <= '0;
        fault_r <= 1'b0;
        // clamp below at zero, above at the field maximum
        if (pn[31]) begin
          press_r <= '0;
        end else if (pn > brc_pkg::K_P_MAX) begin
          press_r <= brc_pkg::K_P_MAX[17:0];
        end else begin
          press_r <= pn[17:0];
        end
      end
      brc_pkg::OP_P_FLT: begin
        kind_r  <= 1'b1;
        temp_r  <= '0;
        press_r <= '0;
        fault_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign res_kind  = kind_r;
  assign res_temp  = temp_r;
  assign res_press = press_r;
  assign res_fault = fault_r;

endmodule

// ===== design/brc_ctrl.sv =====
// Controller: sequences one reading through the datapath and owns the handshakes.
module brc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  brc_pkg::status_t status,
  output brc_pkg::cmd_t    cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_T_MUL  = 20'h00002,
    S_T_X1   = 20'h00004,
    S_T_CHK  = 20'h00008,
    S_DIV    = 20'h00010,
    S_T_FIN  = 20'h00020,
    S_T_FLT  = 20'h00040,
    S_P_SQ   = 20'h00080,
    S_P_X1   = 20'h00100,
    S_P_X2   = 20'h00200,
    S_P_B3   = 20'h00400,
    S_P_X4   = 20'h00800,
    S_P_B4M  = 20'h01000,
    S_P_B7M  = 20'h02000,
    S_P_DIVS = 20'h04000,
    S_P_P    = 20'h08000,
    S_P_X1P  = 20'h10000,
    S_P_X2P  = 20'h20000,
    S_P_FIN  = 20'h40000,
    S_P_FLT  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   kind_r, kind_nxt;
  logic   oval_r, oval_nxt;
  logic   out_free;
  logic   in_fire;
  logic   emit;

  assign out_free = !oval_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd.latch = in_fire;
    cmd.op    = brc_pkg::OP_NONE;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_op;
          state_nxt = in_op ? S_P_SQ : S_T_MUL;
        end
      end
      S_T_MUL: begin cmd.op = brc_pkg::OP_T_MUL; state_nxt = S_T_X1; end
      S_T_X1:  begin cmd.op = brc_pkg::OP_T_X1;  state_nxt = S_T_CHK; end
      S_T_CHK: begin
        cmd.op    = brc_pkg::OP_T_CHK;
        state_nxt = status.den_zero ? S_T_FLT : S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = kind_r ? S_P_P : S_T_FIN;
      end
      S_T_FIN: begin
        // hold until the output word is free
        if (out_free) begin
          cmd.op = brc_pkg::OP_T_FIN; emit = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_T_FLT: begin
        if (out_free) begin
          cmd.op = brc_pkg::OP_T_FLT; emit = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_P_SQ:  begin cmd.op = brc_pkg::OP_P_SQ;  state_nxt = S_P_X1; end
      S_P_X1:  begin cmd.op = brc_pkg::OP_P_X1;  state_nxt = S_P_X2; end
      S_P_X2:  begin cmd.op = brc_pkg::OP_P_X2;  state_nxt = S_P_B3; end
      S_P_B3:  begin cmd.op = brc_pkg::OP_P_B3;  state_nxt = S_P_X4; end
      S_P_X4:  begin cmd.op = brc_pkg::OP_P_X4;  state_nxt = S_P_B4M; end
      S_P_B4M: begin cmd.op = brc_pkg::OP_P_B4M; state_nxt = S_P_B7M; end
      S_P_B7M: begin cmd.op = brc_pkg::OP_P_B7M; state_nxt = S_P_DIVS; end
      S_P_DIVS: begin
        cmd.op    = brc_pkg::OP_P_DIVS;
        state_nxt = status.b4_zero ? S_P_FLT : S_DIV;
      end
      S_P_P:   begin cmd.op = brc_pkg::OP_P_P;   state_nxt = S_P_X1P; end
      S_P_X1P: begin cmd.op = brc_pkg::OP_P_X1P; state_nxt = S_P_X2P; end
      S_P_X2P: begin cmd.op = brc_pkg::OP_P_X2P; state_nxt = S_P_FIN; end
      S_P_FIN: begin
        if (out_free) begin
          cmd.op = brc_pkg::OP_P_FIN; emit = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_P_FLT: begin
        if (out_free) begin
          cmd.op = brc_pkg::OP_P_FLT; emit = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      oval_r  <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("accepted a word while still working");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_done) |=> (state_r == S_T_FIN || state_r == S_P_P))
    else $error("divider result not consumed");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!oval_r || out_ready))
    else $error("result overwrote a pending word");

endmodule

// ===== design/barometer_reading_compensation_core.sv =====
// Top level of the barometer reading compensation core.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | tdata raw reading, tuser op
//  out_    | output    | out_tvalid/out_tready | tdata temp/press/fault, tuser kind
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// The time that a temperature or a pressure word takes is set by the bit-serial
// divider plus the steps of the one shared multiplier.
// One word is worked on at a time; the next is taken while a result still waits.
// A result stalled at the output holds the finished word in its last step.
// Synchronous reset clears control, coefficients and the kept b5; cfg_ready is always high.
module barometer_reading_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] raw_reading
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] temperature_tenths, [33:16] pressure_pa, [34] fault
  output logic [0:0]  out_tuser,  // [0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  brc_pkg::cmd_t    cmd;
  brc_pkg::status_t status;
  logic             res_kind;
  logic [15:0]      res_temp;
  logic [17:0]      res_press;
  logic             res_fault;

  assign cfg_ready = 1'b1;

  brc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser[0]),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  brc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_raw    (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .res_kind  (res_kind),
    .res_temp  (res_temp),
    .res_press (res_press),
    .res_fault (res_fault)
  );

  assign out_tdata = {5'd0, res_fault, res_press, res_temp};
  assign out_tuser = res_kind;

endmodule
